FILE: rtl/core/dfpe_pkg.sv
package dfpe_pkg;

  localparam int FRAME_BITS = 16;
  localparam int FRAME_IDX_W = $clog2(FRAME_BITS);
  localparam int VALUE_W = 11;
  localparam int TICK_W = 17;
  localparam int CNT_W = 32;
  localparam int RAW_W = 16;
  localparam int THRUST_W = 17;
  localparam int ACTION_W = 2;
  localparam int CFG_IDX_W = 2;

  // Queue depth between the front and back halves; must be a power of two.
  localparam int QDEPTH = 2;

  localparam int REST_SLOTS_DEF = 2;
  localparam int MIN_THROTTLE_DEF = 48;
  localparam int THROTTLE_SPAN_DEF = 1999;
  localparam int MAX_VALUE_DEF = 2047;

  localparam logic [15:0] Q15_ONE = 16'h8000;
  localparam logic [27:0] Q15_HALF = 28'd16384;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RAW    = 2'd0,
    ACT_THRUST = 2'd1,
    ACT_STOP   = 2'd2
  } action_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED    = 2'd0,
    CFG_ZERO_TICKS = 2'd1,
    CFG_ONE_TICKS  = 2'd2
  } cfg_idx_e_t;

  typedef struct packed {
    logic              enabled;
    logic [TICK_W-1:0] zero_ticks;
    logic [TICK_W-1:0] one_ticks;
  } dfpe_cfg_t;

  // One queued command: the frame to send or a refusal, plus the state
  // snapshot that every result word of this command reports.
  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic                  refused;
    logic [VALUE_W-1:0]    sent_value;
    logic [CNT_W-1:0]      frames_sent;
    logic [CNT_W-1:0]      errors_seen;
  } dfpe_desc_t;

  function automatic logic [FRAME_BITS-1:0] make_frame(input logic [VALUE_W-1:0] value,
                                                       input logic telem);
    logic [11:0] payload;
    logic [3:0]  crc;
    payload = {value, telem};
    crc = payload[3:0] ^ payload[7:4] ^ payload[11:8];
    return {payload, crc};
  endfunction

endpackage

FILE: rtl/core/dfpe_ifs.sv
interface dfpe_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [dfpe_pkg::ACTION_W-1:0]       action;
  logic [dfpe_pkg::RAW_W-1:0]          raw_value;
  logic                                telemetry_request;
  logic signed [dfpe_pkg::THRUST_W-1:0] thrust_q15;

  modport source (output valid, action, raw_value, telemetry_request, thrust_q15,
                  input ready);
  modport sink (input valid, action, raw_value, telemetry_request, thrust_q15,
                output ready);
endinterface

interface dfpe_res_if;
  logic                         valid;
  logic                         ready;
  logic [dfpe_pkg::TICK_W-1:0]  pulse_ticks;
  logic                         last;
  logic                         status;
  logic [dfpe_pkg::VALUE_W-1:0] sent_value;
  logic [dfpe_pkg::CNT_W-1:0]   frames_sent;
  logic [dfpe_pkg::CNT_W-1:0]   errors_seen;

  modport source (output valid, pulse_ticks, last, status, sent_value, frames_sent,
                  errors_seen, input ready);
  modport sink (input valid, pulse_ticks, last, status, sent_value, frames_sent,
                errors_seen, output ready);
endinterface

interface dfpe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dfpe_pkg::CFG_IDX_W-1:0] index;
  logic [dfpe_pkg::TICK_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/dfpe_front.sv
module dfpe_front #(
  parameter int MIN_THROTTLE = dfpe_pkg::MIN_THROTTLE_DEF,
  parameter int THROTTLE_SPAN = dfpe_pkg::THROTTLE_SPAN_DEF,
  parameter int MAX_VALUE = dfpe_pkg::MAX_VALUE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  dfpe_cmd_if.sink             in_cmd,
  input  logic                 enabled,
  input  logic                 q_full,
  output logic                 q_push,
  output dfpe_pkg::dfpe_desc_t q_desc
);
  import dfpe_pkg::*;

  logic [VALUE_W-1:0] last_sent_r, last_sent_nxt;
  logic [CNT_W-1:0]   frames_r, frames_nxt;
  logic [CNT_W-1:0]   errors_r, errors_nxt;

  logic               accept;
  logic               do_emit;
  logic               do_count;
  logic [VALUE_W-1:0] value;
  logic               telem;
  logic [15:0]        thrust_sat;
  logic [26:0]        product;
  logic [27:0]        rounded;
  logic [13:0]        mapped;

  assign in_cmd.ready = !q_full;
  assign accept = in_cmd.valid && !q_full;

  // Thrust mapping: clamp to 1.0, scale by the span, round halves upwards and add the minimum throttle.
  assign thrust_sat = (in_cmd.thrust_q15[15:0] > Q15_ONE) ? Q15_ONE : in_cmd.thrust_q15[15:0];
  assign product = 27'(thrust_sat) * 27'(THROTTLE_SPAN);
  assign rounded = 28'(product) + Q15_HALF;
  assign mapped = 14'(rounded[27:15]) + 14'(MIN_THROTTLE);

  always_comb begin
    do_emit = 1'b0;
    do_count = 1'b0;
    value = '0;
    telem = 1'b0;
    if (enabled) begin
      unique case (action_e_t'(in_cmd.action))
        ACT_RAW: begin
          if (in_cmd.raw_value > RAW_W'(MAX_VALUE)) begin
            do_count = 1'b1;
          end else begin
            do_emit = 1'b1;
            value = in_cmd.raw_value[VALUE_W-1:0];
            telem = in_cmd.telemetry_request;
          end
        end
        ACT_THRUST: begin
          if (in_cmd.thrust_q15[THRUST_W-1] || in_cmd.thrust_q15 == '0) begin
            do_emit = 1'b1;
          end else if (mapped > 14'(MAX_VALUE)) begin
            do_count = 1'b1;
          end else begin
            do_emit = 1'b1;
            value = mapped[VALUE_W-1:0];
          end
        end
        ACT_STOP: begin
          do_emit = 1'b1;
        end
        default: begin
          do_emit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    last_sent_nxt = last_sent_r;
    frames_nxt = frames_r;
    errors_nxt = errors_r;
    if (accept && do_emit) begin
      last_sent_nxt = value;
      frames_nxt = frames_r + CNT_W'(1);
    end
    if (accept && do_count) begin
      errors_nxt = errors_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sent_r <= '0;
      frames_r <= '0;
      errors_r <= '0;
    end else begin
      last_sent_r <= last_sent_nxt;
      frames_r <= frames_nxt;
      errors_r <= errors_nxt;
    end
  end

  assign q_push = accept;
  assign q_desc.frame = make_frame(value, telem);
  assign q_desc.refused = !do_emit;
  assign q_desc.sent_value = last_sent_nxt;
  assign q_desc.frames_sent = frames_nxt;
  assign q_desc.errors_seen = errors_nxt;

endmodule

FILE: rtl/core/dfpe_queue.sv
module dfpe_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dfpe_pkg::dfpe_desc_t push_desc,
  input  logic                 pop,
  output logic                 full,
  output logic                 empty,
  output dfpe_pkg::dfpe_desc_t head
);
  import dfpe_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  dfpe_desc_t       mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;

  assign full = (count_r == (QAW+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign head = mem_r[rd_ptr_r];

  // Pointers wrap by overflow since the depth is a power of two.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + QAW'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + (QAW+1)'(1);
      2'b01:   count_nxt = count_r - (QAW+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

FILE: rtl/core/dfpe_back.sv
module dfpe_back #(
  parameter int REST_SLOTS = dfpe_pkg::REST_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dfpe_pkg::dfpe_cfg_t  cfg,
  input  logic                 q_empty,
  input  dfpe_pkg::dfpe_desc_t head,
  output logic                 q_pop,
  dfpe_res_if.source           out_res
);
  import dfpe_pkg::*;

  localparam int TOTAL = FRAME_BITS + REST_SLOTS;
  localparam int SLOT_W = $clog2(TOTAL);

  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic                   handshake;
  logic                   is_last;
  logic                   in_frame;
  logic [FRAME_IDX_W-1:0] bit_idx;
  logic                   bit_val;

  assign handshake = out_res.valid && out_res.ready;
  assign is_last = head.refused || (slot_r == SLOT_W'(TOTAL - 1));
  assign in_frame = ({1'b0, slot_r} < (SLOT_W+1)'(FRAME_BITS));
  assign bit_idx = FRAME_IDX_W'(FRAME_BITS - 1) - slot_r[FRAME_IDX_W-1:0];
  assign bit_val = head.frame[bit_idx];
  assign q_pop = handshake && is_last;

  always_comb begin
    slot_nxt = slot_r;
    if (q_pop) begin
      slot_nxt = '0;
    end else if (handshake) begin
      slot_nxt = slot_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign out_res.valid = !q_empty;
  assign out_res.pulse_ticks = (head.refused || !in_frame) ? '0 :
                               (bit_val ? cfg.one_ticks : cfg.zero_ticks);
  assign out_res.last = is_last;
  assign out_res.status = head.refused;
  assign out_res.sent_value = head.sent_value;
  assign out_res.frames_sent = head.frames_sent;
  assign out_res.errors_seen = head.errors_seen;

endmodule

FILE: rtl/core/dshot_frame_pulse_encoder.sv
// The first word of a command that finds the queue empty is offered in the cycle after it is taken.
// Throughput: a frame gives 16 + REST_SLOTS words and a refusal one word, one word per
// cycle while the sink is ready; the back half's slot counter sets this pace, and a
// two-entry queue lets the next command be taken while the current one is sent.
// Reset clears the configuration, the value and frame/error counters, and the queue.
module dshot_frame_pulse_encoder #(
  parameter int REST_SLOTS = dfpe_pkg::REST_SLOTS_DEF,
  parameter int MIN_THROTTLE = dfpe_pkg::MIN_THROTTLE_DEF,
  parameter int THROTTLE_SPAN = dfpe_pkg::THROTTLE_SPAN_DEF,
  parameter int MAX_VALUE = dfpe_pkg::MAX_VALUE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dfpe_cmd_if.sink   in_cmd,
  dfpe_res_if.source out_res,
  dfpe_cfg_if.sink   cfg_wr
);
  import dfpe_pkg::*;

  dfpe_cfg_t  cfg_r, cfg_nxt;
  dfpe_desc_t push_desc;
  dfpe_desc_t head;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (cfg_idx_e_t'(cfg_wr.index))
        CFG_ENABLED:    cfg_nxt.enabled = cfg_wr.data[0];
        CFG_ZERO_TICKS: cfg_nxt.zero_ticks = cfg_wr.data;
        CFG_ONE_TICKS:  cfg_nxt.one_ticks = cfg_wr.data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dfpe_front #(
    .MIN_THROTTLE (MIN_THROTTLE),
    .THROTTLE_SPAN(THROTTLE_SPAN),
    .MAX_VALUE    (MAX_VALUE)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_cmd (in_cmd),
    .enabled(cfg_r.enabled),
    .q_full (q_full),
    .q_push (q_push),
    .q_desc (push_desc)
  );

  dfpe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_desc(push_desc),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  dfpe_back #(
    .REST_SLOTS(REST_SLOTS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_empty(q_empty),
    .head   (head),
    .q_pop  (q_pop),
    .out_res(out_res)
  );

`ifndef NO_ASSERTIONS
  // A refused command is a single zero-width word.
  a_refuse_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.status |-> out_res.last && out_res.pulse_ticks == '0)
    else $error("refusal word not marked last or carries ticks");

  // Within a frame, the next word is offered straight after a taken one.
  a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.ready && !out_res.last |=> out_res.valid && !out_res.status)
    else $error("frame broken off before its last word");

  // The front only stalls when the queue holds work for the back half.
  a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    !in_cmd.ready |-> out_res.valid)
    else $error("input stalled with nothing queued");

  // The frame counter in the snapshot stays put across the words of one frame.
  a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.ready && !out_res.last |=> $stable(out_res.frames_sent))
    else $error("state snapshot changed within a frame");
`endif

endmodule

FILE: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dfpe_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int Q15_FRAC = 15;
  localparam int TICKS_MAX = 65536;

  // Codes that the package leaves unnamed but the fields can carry.
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {RX_STEADY, RX_PATTERN, RX_SLUGGISH} rx_mode_t;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [RAW_W-1:0]    raw_value;
    logic                telem;
    logic [THRUST_W-1:0] thrust;
  } command_t;

  typedef struct {
    logic [TICK_W-1:0]  pulse_ticks;
    logic               last;
    logic               status;
    logic [VALUE_W-1:0] sent_value;
    logic [CNT_W-1:0]   frames_sent;
    logic [CNT_W-1:0]   errors_seen;
  } pulse_word_t;

  logic clk = 1'b0;
  logic rst_n;

  dfpe_cmd_if cmd_bus();
  dfpe_res_if res_bus();
  dfpe_cfg_if cfg_bus();

  dshot_frame_pulse_encoder uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (cmd_bus),
    .out_res (res_bus),
    .cfg_wr  (cfg_bus)
  );

  always #(CLK_HALF) clk = ~clk;

  // Own copy of the configuration and of the encoder's counters.
  logic               cfg_enabled;
  logic [TICK_W-1:0]  cfg_zero_ticks;
  logic [TICK_W-1:0]  cfg_one_ticks;
  logic [VALUE_W-1:0] value_sent_q;
  logic [CNT_W-1:0]   frames_q;
  logic [CNT_W-1:0]   errors_q;

  pulse_word_t expected_words[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  rx_mode_t    rx_mode = RX_STEADY;
  logic [4:0]  stall_step = '0;
  logic [31:0] stall_pattern = '1;

  function automatic void push_word(input logic [TICK_W-1:0] ticks, input logic last,
                                    input logic status);
    pulse_word_t w;
    w.pulse_ticks = ticks;
    w.last        = last;
    w.status      = status;
    w.sent_value  = value_sent_q;
    w.frames_sent = frames_q;
    w.errors_seen = errors_q;
    expected_words.push_back(w);
  endfunction

  function automatic void emit_frame(input logic [VALUE_W-1:0] value, input logic telem);
    logic [11:0]           payload;
    logic [3:0]            crc;
    logic [FRAME_BITS-1:0] frame;
    int                    total;
    int                    k;
    payload = {value, telem};
    crc = payload[3:0] ^ payload[7:4] ^ payload[11:8];
    frame = {payload, crc};
    value_sent_q = value;
    frames_q = frames_q + 1'b1;
    total = FRAME_BITS + REST_SLOTS_DEF;
    for (k = 0; k < total; k++) begin
      if (k < FRAME_BITS) begin
        push_word(frame[FRAME_BITS-1-k] ? cfg_one_ticks : cfg_zero_ticks, k == total - 1, 1'b0);
      end else begin
        push_word('0, k == total - 1, 1'b0);
      end
    end
  endfunction

  function automatic void send_value(input int unsigned value, input logic telem);
    if (value > MAX_VALUE_DEF) begin
      errors_q = errors_q + 1'b1;
      push_word('0, 1'b1, 1'b1);
    end else begin
      emit_frame(value[VALUE_W-1:0], telem);
    end
  endfunction

  function automatic void encode_command(input command_t c);
    int unsigned t;
    int unsigned v;
    if (!cfg_enabled) begin
      push_word('0, 1'b1, 1'b1);
      return;
    end
    case (c.action)
      ACT_RAW: send_value(32'(c.raw_value), c.telem);
      ACT_THRUST: begin
        // Zero and negative thrust both mean motor stop.
        if (c.thrust[THRUST_W-1] || c.thrust == '0) begin
          emit_frame('0, 1'b0);
        end else begin
          t = 32'(c.thrust);
          if (t > Q15_ONE) t = 32'(Q15_ONE);
          v = MIN_THROTTLE_DEF + ((t * THROTTLE_SPAN_DEF + Q15_HALF) >> Q15_FRAC);
          send_value(v, 1'b0);
        end
      end
      ACT_STOP: emit_frame('0, 1'b0);
      default: push_word('0, 1'b1, 1'b1);
    endcase
  endfunction

  task automatic check_word();
    pulse_word_t w;
    if (expected_words.size() == 0) begin
      $error("unexpected word: pulse_ticks %0d last %0b status %0b",
             res_bus.pulse_ticks, res_bus.last, res_bus.status);
      fail_count++;
      return;
    end
    w = expected_words.pop_front();
    if (res_bus.pulse_ticks !== w.pulse_ticks) begin
      $error("pulse_ticks: expected %0d, got %0d", w.pulse_ticks, res_bus.pulse_ticks);
      fail_count++;
    end
    if (res_bus.last !== w.last) begin
      $error("last: expected %0b, got %0b", w.last, res_bus.last);
      fail_count++;
    end
    if (res_bus.status !== w.status) begin
      $error("status: expected %0b, got %0b", w.status, res_bus.status);
      fail_count++;
    end
    if (res_bus.sent_value !== w.sent_value) begin
      $error("sent_value: expected %0d, got %0d", w.sent_value, res_bus.sent_value);
      fail_count++;
    end
    if (res_bus.frames_sent !== w.frames_sent) begin
      $error("frames_sent: expected %0d, got %0d", w.frames_sent, res_bus.frames_sent);
      fail_count++;
    end
    if (res_bus.errors_seen !== w.errors_seen) begin
      $error("errors_seen: expected %0d, got %0d", w.errors_seen, res_bus.errors_seen);
      fail_count++;
    end
  endtask

  // Result side: check each accepted word, then choose ready for the next edge.
  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) check_word();
    stall_step <= stall_step + 1'b1;
    if (stall_step == '1) stall_pattern <= $urandom | $urandom;
    case (rx_mode)
      RX_STEADY: res_bus.ready <= 1'b1;
      RX_PATTERN: res_bus.ready <= stall_pattern[stall_step];
      default: res_bus.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      CFG_ENABLED: cfg_enabled = data[0];
      CFG_ZERO_TICKS: cfg_zero_ticks = data;
      CFG_ONE_TICKS: cfg_one_ticks = data;
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [TICK_W-1:0] zero_ticks,
                            input logic [TICK_W-1:0] one_ticks);
    write_register(CFG_ZERO_TICKS, zero_ticks);
    write_register(CFG_ONE_TICKS, one_ticks);
  endtask

  // Leaves valid high so that a following command goes out back to back.
  task automatic send_cmd(input command_t c);
    cmd_bus.valid             <= 1'b1;
    cmd_bus.action            <= c.action;
    cmd_bus.raw_value         <= c.raw_value;
    cmd_bus.telemetry_request <= c.telem;
    cmd_bus.thrust_q15        <= c.thrust;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    encode_command(c);
  endtask

  task automatic idle_sender(input int cycles);
    cmd_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic await_quiet();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic command_t make_cmd(input logic [ACTION_W-1:0] action,
                                        input logic [RAW_W-1:0] raw_value,
                                        input logic telem,
                                        input logic [THRUST_W-1:0] thrust);
    command_t c;
    c.action    = action;
    c.raw_value = raw_value;
    c.telem     = telem;
    c.thrust    = thrust;
    return c;
  endfunction

  function automatic command_t random_cmd();
    command_t c;
    int       sel;
    sel = $urandom_range(0, 99);
    c.raw_value = RAW_W'($urandom);
    c.telem     = 1'($urandom);
    c.thrust    = THRUST_W'($urandom);
    if (sel < 35) begin
      c.action    = ACT_RAW;
      c.raw_value = RAW_W'($urandom_range(0, MAX_VALUE_DEF));
    end else if (sel < 45) begin
      c.action = ACT_RAW;
    end else if (sel < 80) begin
      c.action = ACT_THRUST;
      if ($urandom_range(0, 9) < 6) c.thrust = THRUST_W'($urandom_range(1, Q15_ONE));
    end else if (sel < 95) begin
      c.action = ACT_STOP;
    end else begin
      c.action = ACT_UNKNOWN;
    end
    return c;
  endfunction

  // Bursts of random length; with max_gap zero the sender never idles between bursts, save at pause_at.
  task automatic run_random(input int count, input int max_gap, input int pause_at);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < count) begin
          send_cmd(random_cmd());
          sent++;
          if (sent == pause_at) await_quiet();
        end
      end
      if (max_gap > 0) idle_sender($urandom_range(1, max_gap));
    end
    await_quiet();
  endtask

  task automatic test_disabled_refusals();
    rx_mode = RX_STEADY;
    write_register(CFG_UNUSED, '1);
    send_cmd(make_cmd(ACT_RAW, 16'd100, 1'b1, '0));
    send_cmd(make_cmd(ACT_RAW, 16'hFFFF, 1'b0, '0));
    send_cmd(make_cmd(ACT_THRUST, '0, 1'b0, 17'd16384));
    send_cmd(make_cmd(ACT_STOP, '0, 1'b0, '0));
    send_cmd(make_cmd(ACT_UNKNOWN, '0, 1'b0, '0));
    await_quiet();
  endtask

  task automatic test_directed_frames();
    rx_mode = RX_PATTERN;
    write_register(CFG_ENABLED, TICK_W'(1));
    set_timing('0, TICK_W'(TICKS_MAX));
    send_cmd(make_cmd(ACT_RAW, 16'd0, 1'b0, '0));
    send_cmd(make_cmd(ACT_RAW, 16'd0, 1'b1, '0));
    send_cmd(make_cmd(ACT_RAW, RAW_W'(MAX_VALUE_DEF), 1'b1, '0));
    send_cmd(make_cmd(ACT_RAW, RAW_W'(MAX_VALUE_DEF + 1), 1'b0, '0));
    send_cmd(make_cmd(ACT_RAW, 16'hFFFF, 1'b1, '1));
    send_cmd(make_cmd(ACT_RAW, 16'h0555, 1'b0, '0));
    send_cmd(make_cmd(ACT_RAW, 16'h02AA, 1'b1, '0));
    idle_sender(3);
    // Zero, the most negative and minus one thrust all give motor stop.
    send_cmd(make_cmd(ACT_THRUST, '0, 1'b1, 17'h00000));
    send_cmd(make_cmd(ACT_THRUST, '0, 1'b1, 17'h10000));
    send_cmd(make_cmd(ACT_THRUST, '1, 1'b1, 17'h1FFFF));
    send_cmd(make_cmd(ACT_THRUST, '0, 1'b0, 17'd1));
    // Half way lands exactly on a half, which rounds up.
    send_cmd(make_cmd(ACT_THRUST, '0, 1'b0, 17'd16384));
    send_cmd(make_cmd(ACT_THRUST, '0, 1'b0, 17'd32767));
    send_cmd(make_cmd(ACT_THRUST, '0, 1'b0, 17'd32768));
    send_cmd(make_cmd(ACT_THRUST, '0, 1'b0, 17'd32769));
    send_cmd(make_cmd(ACT_THRUST, '0, 1'b0, 17'h0FFFF));
    send_cmd(make_cmd(ACT_STOP, '1, 1'b1, '1));
    send_cmd(make_cmd(ACT_UNKNOWN, '1, 1'b1, '1));
    await_quiet();
  endtask

  task automatic test_random_timings();
    rx_mode = RX_STEADY;
    set_timing(TICK_W'(TICKS_MAX), '0);
    run_random(100, 0, 0);
    rx_mode = RX_PATTERN;
    set_timing(TICK_W'($urandom_range(0, TICKS_MAX)), TICK_W'($urandom_range(0, TICKS_MAX)));
    run_random(120, 20, 60);
    rx_mode = RX_SLUGGISH;
    set_timing(17'd45, 17'd90);
    run_random(100, 40, 0);
    rx_mode = RX_PATTERN;
    set_timing(TICK_W'($urandom_range(0, TICKS_MAX)), TICK_W'($urandom_range(0, TICKS_MAX)));
    run_random(110, 8, 30);
  endtask

  task automatic test_random_disabled();
    rx_mode = RX_PATTERN;
    write_register(CFG_ENABLED, TICK_W'(0));
    run_random(30, 10, 0);
    write_register(CFG_ENABLED, TICK_W'(1));
    rx_mode = RX_STEADY;
    run_random(20, 0, 0);
  endtask

  initial begin
    rst_n                     <= 1'b0;
    cmd_bus.valid             <= 1'b0;
    cmd_bus.action            <= ACT_STOP;
    cmd_bus.raw_value         <= '0;
    cmd_bus.telemetry_request <= 1'b0;
    cmd_bus.thrust_q15        <= '0;
    cfg_bus.valid             <= 1'b0;
    cfg_bus.index             <= CFG_ENABLED;
    cfg_bus.data              <= '0;
    cfg_enabled    = 1'b0;
    cfg_zero_ticks = '0;
    cfg_one_ticks  = '0;
    value_sent_q   = '0;
    frames_q       = '0;
    errors_q       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_disabled_refusals();
    test_directed_frames();
    test_random_timings();
    test_random_disabled();

    await_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
